// ===== design/kbs_pkg.sv =====
// ----------------------------------------------------------------------------
// kbs_pkg
// Shared types and constants for the keyframe bracket search block.
// ----------------------------------------------------------------------------
`default_nettype none

package kbs_pkg;

  localparam int MAX_KEYFRAMES_DEF = 64;

  // Field widths
  localparam int KEY_IDX_W  = 6;
  localparam int TIME_W     = 31;
  localparam int QTIME_W    = 32;
  localparam int CNT_CFG_W  = 7;
  localparam int PROG_W     = 17;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  // Operation codes (in_tuser)
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 2'd1;

  localparam logic [PROG_W-1:0] Q_ONE = 17'h10000;

  typedef struct packed {
    logic write_key;   // store the load word into the table
    logic load_query;  // latch query time and count
    logic scan_start;
    logic div_start;
    logic out_load;
  } kbs_cmd_t;

  typedef struct packed {
    logic q_invalid;
    logic scan_done;
    logic div_done;
    logic out_free;
  } kbs_sts_t;

endpackage

`default_nettype wire

// ===== design/keyframe_bracket_search.sv =====
// ----------------------------------------------------------------------------
// keyframe_bracket_search
// Keyframe table with bracket lookup and Q1.16 progression between keys.
// ----------------------------------------------------------------------------
// Load words (tuser = 0) write one timestamp into the table and give no
// result. Query words (tuser = 1) give one result word: an out-of-range
// time or an empty table returns found = 0 without a scan; otherwise the
// table RAM is scanned one entry per cycle and a 16-step restoring divider
// forms the fraction. The block takes a new word only when the previous
// query has reached the result register; a waiting result does not block
// loads.
`default_nettype none

module keyframe_bracket_search #(
  parameter int MAX_KEYFRAMES = kbs_pkg::MAX_KEYFRAMES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // config port
  input  wire logic                                 cfg_we,
  input  wire logic [kbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [kbs_pkg::TIME_W-1:0]           cfg_wdata,
  // input stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [5:0] key_index, [36:6] key_time, [68:37] query_time, [71:69] zero
  input  wire logic [kbs_pkg::IN_DATA_W-1:0]        in_tdata,
  // [0] operation
  input  wire logic                                 in_tuser,
  // result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [5:0] prev_index, [11:6] next_index, [28:12] progression, [31:29] zero
  output logic [kbs_pkg::OUT_DATA_W-1:0]            out_tdata,
  // [0] found
  output logic                                      out_tuser
);

  kbs_pkg::kbs_cmd_t cmd;
  kbs_pkg::kbs_sts_t sts;

  logic [kbs_pkg::KEY_IDX_W-1:0] prev_idx, next_idx;
  logic [kbs_pkg::PROG_W-1:0]    prog;

  kbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  kbs_dp #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .key_index  (in_tdata[5:0]),
    .key_time   (in_tdata[36:6]),
    .query_time ($signed(in_tdata[68:37])),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_found  (out_tuser),
    .out_prev   (prev_idx),
    .out_next   (next_idx),
    .out_prog   (prog)
  );

  assign out_tdata = {3'b000, prog, next_idx, prev_idx};

endmodule

`default_nettype wire

// ===== design/kbs_ram.sv =====
// ----------------------------------------------------------------------------
// kbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/kbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbs_ctrl
// Sequencer for loads and queries: check, scan, divide, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_op,
  input  wire kbs_pkg::kbs_sts_t sts,
  output kbs_pkg::kbs_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == kbs_pkg::OP_LOAD) begin
          cmd.write_key = 1'b1;
        end else if (accept) begin
          cmd.load_query = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.q_invalid) begin
          state_nxt = S_OUT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/kbs_dp.sv =====
// ----------------------------------------------------------------------------
// kbs_dp
// Datapath: config registers, timestamp table, bracket scan, Q1.16 divider
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_dp #(
  parameter int MAX_KEYFRAMES = kbs_pkg::MAX_KEYFRAMES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [kbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [kbs_pkg::TIME_W-1:0]          cfg_wdata,
  input  wire logic [kbs_pkg::KEY_IDX_W-1:0]       key_index,
  input  wire logic [kbs_pkg::TIME_W-1:0]          key_time,
  input  wire logic signed [kbs_pkg::QTIME_W-1:0]  query_time,
  input  wire kbs_pkg::kbs_cmd_t                   cmd,
  output kbs_pkg::kbs_sts_t                        sts,
  input  wire logic                                out_tready,
  output logic                                     out_valid,
  output logic                                     out_found,
  output logic [kbs_pkg::KEY_IDX_W-1:0]            out_prev,
  output logic [kbs_pkg::KEY_IDX_W-1:0]            out_next,
  output logic [kbs_pkg::PROG_W-1:0]               out_prog
);

  localparam int AW  = $clog2(MAX_KEYFRAMES);
  localparam int CW  = $clog2(MAX_KEYFRAMES + 1);
  localparam int TW  = kbs_pkg::TIME_W;
  localparam int DCW = $clog2(kbs_pkg::FRAC_BITS);

  // Config registers
  logic [TW-1:0]                   anim_len_r;
  logic [kbs_pkg::CNT_CFG_W-1:0]   key_count_r;

  // Query context
  logic [TW-1:0]  t_r;
  logic [CW-1:0]  count_r;
  logic           q_invalid_r;
  logic [CW-1:0]  count_in;

  // Scan
  logic           scan_active_r, issuing_r, dvalid_r, scan_done_r;
  logic [AW-1:0]  rd_idx_r, cmp_idx_r;
  logic [TW-1:0]  prev_time_r;
  logic [TW-1:0]  rd_data;
  logic           hit, at_last, issue_last, scan_hit;

  // Divider
  logic signed [TW:0]               num_r, den_r;
  logic [TW-1:0]                    rem_r;
  logic [kbs_pkg::FRAC_BITS-1:0]    quo_r;
  logic [DCW-1:0]                   div_cnt_r;
  logic                             div_busy_r, div_done_r;
  logic [kbs_pkg::PROG_W-1:0]       prog_r;
  logic [TW:0]                      rem2;
  logic                             ge;

  // Bracket
  logic [AW-1:0] prev_idx_r, next_idx_r;

  // Result register
  logic                          out_valid_r, out_found_r;
  logic [kbs_pkg::KEY_IDX_W-1:0] out_prev_r, out_next_r;
  logic [kbs_pkg::PROG_W-1:0]    out_prog_r;

  logic ram_we;

  assign ram_we = cmd.write_key &&
                  (32'(key_index) < 32'(MAX_KEYFRAMES));

  kbs_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_KEYFRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(key_index)),
    .wdata (key_time),
    .re    (issuing_r),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  assign count_in = (32'(key_count_r) > 32'(MAX_KEYFRAMES)) ? CW'(MAX_KEYFRAMES)
                                                             : CW'(key_count_r);

  // t is known in [0, anim_length] once the scan runs
  assign hit        = (cmp_idx_r != '0) && (rd_data > t_r);
  assign at_last    = (CW'(cmp_idx_r) == count_r - CW'(1));
  assign issue_last = (CW'(rd_idx_r) == count_r - CW'(1));
  assign scan_hit   = scan_active_r && dvalid_r && hit;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = (rem2 >= {1'b0, den_r[TW-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anim_len_r    <= '0;
      key_count_r   <= '0;
      scan_active_r <= 1'b0;
      issuing_r     <= 1'b0;
      dvalid_r      <= 1'b0;
      scan_done_r   <= 1'b0;
      div_busy_r    <= 1'b0;
      div_done_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kbs_pkg::CFG_ANIM_LENGTH: anim_len_r  <= cfg_wdata;
          kbs_pkg::CFG_KEY_COUNT:   key_count_r <= cfg_wdata[kbs_pkg::CNT_CFG_W-1:0];
          default: ;
        endcase
      end

      if (cmd.load_query) begin
        t_r         <= query_time[TW-1:0];
        count_r     <= count_in;
        q_invalid_r <= (count_in == '0) || query_time[kbs_pkg::QTIME_W-1] ||
                       (query_time > $signed({1'b0, anim_len_r}));
      end

      // Scan: one read issued per cycle, compared in the next cycle
      dvalid_r  <= issuing_r && !cmd.scan_start;
      cmp_idx_r <= rd_idx_r;
      if (cmd.scan_start) begin
        rd_idx_r      <= '0;
        issuing_r     <= 1'b1;
        scan_active_r <= 1'b1;
        scan_done_r   <= 1'b0;
      end else begin
        if (issuing_r) begin
          if (issue_last || scan_hit) begin
            issuing_r <= 1'b0;
          end else begin
            rd_idx_r <= rd_idx_r + AW'(1);
          end
        end
        if (scan_active_r && dvalid_r) begin
          if (hit) begin
            num_r         <= $signed({1'b0, t_r}) - $signed({1'b0, prev_time_r});
            den_r         <= $signed({1'b0, rd_data}) - $signed({1'b0, prev_time_r});
            prev_idx_r    <= cmp_idx_r - AW'(1);
            next_idx_r    <= cmp_idx_r;
            scan_active_r <= 1'b0;
            scan_done_r   <= 1'b1;
          end else if (at_last) begin
            // past the last keyframe: wrap to keyframe 0 against the length
            num_r         <= $signed({1'b0, t_r}) - $signed({1'b0, rd_data});
            den_r         <= $signed({1'b0, anim_len_r}) - $signed({1'b0, rd_data});
            prev_idx_r    <= cmp_idx_r;
            next_idx_r    <= '0;
            scan_active_r <= 1'b0;
            scan_done_r   <= 1'b1;
          end else begin
            prev_time_r <= rd_data;
          end
        end
      end

      // Restoring divider, one quotient bit per cycle
      if (cmd.div_start) begin
        scan_done_r <= 1'b0;
        quo_r       <= '0;
        rem_r       <= num_r[TW-1:0];
        div_cnt_r   <= DCW'(kbs_pkg::FRAC_BITS - 1);
        if (num_r[TW] || den_r[TW] || den_r == '0) begin
          prog_r     <= '0;
          div_done_r <= 1'b1;
        end else if (num_r >= den_r) begin
          prog_r     <= kbs_pkg::Q_ONE;   // saturates at one
          div_done_r <= 1'b1;
        end else begin
          div_busy_r <= 1'b1;
          div_done_r <= 1'b0;
        end
      end else if (div_busy_r) begin
        rem_r <= ge ? TW'(rem2 - {1'b0, den_r[TW-1:0]}) : TW'(rem2);
        quo_r <= {quo_r[kbs_pkg::FRAC_BITS-2:0], ge};
        if (div_cnt_r == '0) begin
          prog_r     <= {1'b0, quo_r[kbs_pkg::FRAC_BITS-2:0], ge};
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
        end else begin
          div_cnt_r <= div_cnt_r - DCW'(1);
        end
      end else if (cmd.out_load) begin
        div_done_r <= 1'b0;
      end

      // Result register
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        out_found_r <= !q_invalid_r;
        out_prev_r  <= q_invalid_r ? '0 : kbs_pkg::KEY_IDX_W'(prev_idx_r);
        out_next_r  <= q_invalid_r ? '0 : kbs_pkg::KEY_IDX_W'(next_idx_r);
        out_prog_r  <= q_invalid_r ? '0 : prog_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.q_invalid = q_invalid_r;
  assign sts.scan_done = scan_done_r;
  assign sts.div_done  = div_done_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_prev  = out_prev_r;
  assign out_next  = out_next_r;
  assign out_prog  = out_prog_r;

endmodule

`default_nettype wire

// ===== design/kbs_checker.sv =====
// ----------------------------------------------------------------------------
// kbs_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  // stalled result word must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("miss result with nonzero fields");

  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[28:12] <= 17'h10000)
    else $error("progression above one");

  // unless wrapped, next follows prev
  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata[11:6] != 6'd0 |->
      out_tdata[11:6] == out_tdata[5:0] + 6'd1)
    else $error("next index does not follow prev index");

endmodule

bind keyframe_bracket_search kbs_checker u_kbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== verif/bracket_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_checker
// Watches the config port and both streams of the keyframe bracket search
// block. Keeps a shadow keyframe table and register set. Predicts each query
// result and compares it field by field with the words the block returns.
// ----------------------------------------------------------------------------

module bracket_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kbs_pkg::TIME_W-1:0]        cfg_wdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // [5:0] key_index, [36:6] key_time, [68:37] query_time, [71:69] zero
  input  logic [kbs_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // [5:0] prev_index, [11:6] next_index, [28:12] progression, [31:29] zero
  input  logic [kbs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] found
  input  logic                              out_tuser,
  input  logic                              end_check,
  output int                                pending,
  output int                                fail_count
);

  import kbs_pkg::*;

  localparam int KTIME_LSB = KEY_IDX_W;
  localparam int QTIME_LSB = KEY_IDX_W + TIME_W;
  localparam int NEXT_LSB  = KEY_IDX_W;
  localparam int PROG_LSB  = 2 * KEY_IDX_W;

  typedef struct packed {
    logic                 found;
    logic [KEY_IDX_W-1:0] prev_idx;
    logic [KEY_IDX_W-1:0] next_idx;
    logic [PROG_W-1:0]    progression;
  } bracket_t;

  logic [TIME_W-1:0]    key_times [MAX_KEYFRAMES_DEF];
  logic [TIME_W-1:0]    anim_len;
  logic [CNT_CFG_W-1:0] key_count;
  bracket_t             expected_brackets [$];
  bracket_t             want;
  logic                 end_seen;
  int                   errors;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
  endtask

  task automatic enqueue_bracket(input bracket_t b);
    expected_brackets.insert(expected_brackets.size(), b);
  endtask

  // Q1.16 fraction, truncated, clipped to one; zero when undefined
  function automatic logic [PROG_W-1:0] q16_frac(input longint num, input longint den);
    longint q_one;
    longint q;
    q_one = Q_ONE;
    if (num < 0 || den <= 0) return '0;
    q = (num * q_one) / den;
    if (q > q_one) q = q_one;
    return q[PROG_W-1:0];
  endfunction

  function automatic bracket_t locate_bracket(input logic signed [QTIME_W-1:0] qtime);
    bracket_t res;
    longint   t;
    longint   len;
    longint   lo;
    longint   hi;
    int       cnt;
    logic     hit;
    t   = qtime;
    len = anim_len;
    cnt = (key_count > MAX_KEYFRAMES_DEF) ? MAX_KEYFRAMES_DEF : key_count;
    res = '0;
    if (cnt == 0 || t < 0 || t > len) return res;
    res.found = 1'b1;
    lo = key_times[cnt-1];
    res.prev_idx = KEY_IDX_W'(cnt - 1);
    res.next_idx = '0;
    res.progression = q16_frac(t - lo, len - lo);
    hit = 1'b0;
    for (int i = 1; i < cnt; i++) begin
      hi = key_times[i];
      if (!hit && hi > t) begin
        hit = 1'b1;
        lo = key_times[i-1];
        res.prev_idx = KEY_IDX_W'(i - 1);
        res.next_idx = KEY_IDX_W'(i);
        res.progression = q16_frac(t - lo, hi - lo);
      end
    end
    return res;
  endfunction

  initial begin
    errors   = 0;
    end_seen = 1'b0;
    for (int i = 0; i < MAX_KEYFRAMES_DEF; i++) key_times[i] = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      anim_len  = '0;
      key_count = '0;
      expected_brackets.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_brackets.size() == 0) begin
          report_mismatch($sformatf("result word %h/%b with nothing pending",
                                    out_tdata, out_tuser));
        end else begin
          want = expected_brackets.pop_front();
          check_field("found", out_tuser, want.found);
          check_field("prev_index", out_tdata[0 +: KEY_IDX_W], want.prev_idx);
          check_field("next_index", out_tdata[NEXT_LSB +: KEY_IDX_W], want.next_idx);
          check_field("progression", out_tdata[PROG_LSB +: PROG_W], want.progression);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_QUERY)
          enqueue_bracket(locate_bracket(in_tdata[QTIME_LSB +: QTIME_W]));
        else
          key_times[in_tdata[0 +: KEY_IDX_W]] = in_tdata[KTIME_LSB +: TIME_W];
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANIM_LENGTH: anim_len = cfg_wdata;
          CFG_KEY_COUNT:   key_count = cfg_wdata[CNT_CFG_W-1:0];
          default: ;
        endcase
      end
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        if (expected_brackets.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_brackets.size()));
      end
    end
    pending <= expected_brackets.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyframe bracket search block.
// A directed pass covers range edges, loop wrap, zero-width and unordered
// intervals and ignored register indexes; random phases then reload the table
// with ordered keys under varying length, count and flow control.
// ----------------------------------------------------------------------------

module tb_top;

  import kbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 100;
  localparam int ITEM_TARGET    = 650;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [TIME_W-1:0]    LEN_MAX      = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH
  } flow_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [TIME_W-1:0]      cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tuser;
  logic                   end_check  = 1'b0;
  logic                   hold_req   = 1'b0;
  logic                   hold_seen  = 1'b0;
  int                     hold_left  = 0;
  int                     idle_cycles = 0;
  int                     pending;
  int                     fail_count;
  int                     items_sent = 0;
  flow_mode_t             mode       = FLOW_FREE;

  // stimulus-side copy of what was loaded, used only to aim query times
  logic [TIME_W-1:0]      tb_keys [MAX_KEYFRAMES_DEF];
  logic [TIME_W-1:0]      cur_len;
  int                     cur_nk;

  always #2 clk = ~clk;

  keyframe_bracket_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  bracket_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .end_check  (end_check),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // result side: long hold-off on request, otherwise per-phase stalls
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (mode)
        FLOW_SNK_STALL: out_tready <= ($urandom_range(99) >= 72);
        FLOW_BOTH:      out_tready <= ($urandom_range(99) >= 15);
        default:        out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic op, input logic [KEY_IDX_W-1:0] kidx,
                           input logic [TIME_W-1:0] ktime,
                           input logic [QTIME_W-1:0] qtime);
    while ((mode == FLOW_SRC_IDLE && $urandom_range(99) < 72) ||
           (mode == FLOW_BOTH && $urandom_range(99) < 15)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, qtime, ktime, kidx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_load(input int kidx, input logic [TIME_W-1:0] ktime);
    tb_keys[kidx] = ktime;
    send_word(OP_LOAD, KEY_IDX_W'(kidx), ktime, $urandom);
  endtask

  task automatic send_query(input logic [QTIME_W-1:0] qtime);
    send_word(OP_QUERY, KEY_IDX_W'($urandom), TIME_W'($urandom), qtime);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // drain all results, then give trailing loads time to land in the table
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input int cnt);
    logic [TIME_W-1:0] val;
    val = TIME_W'($urandom);
    val[CNT_CFG_W-1:0] = CNT_CFG_W'(cnt);
    cfg_write(CFG_KEY_COUNT, val);
  endtask

  // ordered keys in [0, len], with some repeated timestamps
  task automatic load_table();
    longint cur;
    int     step_max;
    cur = 0;
    step_max = (cur_nk == 0) ? 0 : cur_len / cur_nk;
    for (int i = 0; i < cur_nk; i++) begin
      if ($urandom_range(9) != 0) cur += $urandom_range(step_max, 0);
      if (cur > cur_len) cur = cur_len;
      send_load(i, TIME_W'(cur));
    end
  endtask

  function automatic logic [QTIME_W-1:0] pick_query_time();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(cur_len, 0);
    if (r < 65 && cur_nk > 0)
      return {1'b0, tb_keys[$urandom_range(cur_nk - 1, 0)]} + $urandom_range(2, 0) - 1;
    if (r < 75) return {1'b0, cur_len} + $urandom_range(1, 0);
    if (r < 85) return $urandom | 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic run_phase(input int phase_no);
    int cnt;
    int n_items;
    wait_idle();
    mode = flow_mode_t'(phase_no % 4);
    case (phase_no)
      0: begin cnt = MAX_KEYFRAMES_DEF; cur_len = LEN_MAX; end
      1: begin cnt = 127; cur_len = TIME_W'($urandom_range(5000, 1)); end
      2: begin cnt = $urandom_range(8, 2); cur_len = '0; end
      default: begin
        case ($urandom_range(9))
          0:       cnt = 0;
          1:       cnt = 1;
          2:       cnt = MAX_KEYFRAMES_DEF;
          3:       cnt = $urandom_range(127, MAX_KEYFRAMES_DEF + 1);
          4, 5:    cnt = $urandom_range(MAX_KEYFRAMES_DEF, 2);
          default: cnt = $urandom_range(8, 2);
        endcase
        case ($urandom_range(7))
          0:       cur_len = '0;
          1:       cur_len = LEN_MAX;
          2, 3:    cur_len = TIME_W'($urandom_range(5000, 1));
          default: cur_len = TIME_W'($urandom_range(LEN_MAX, 0));
        endcase
      end
    endcase
    cur_nk = (cnt > MAX_KEYFRAMES_DEF) ? MAX_KEYFRAMES_DEF : cnt;
    if ($urandom_range(3) == 0) cfg_write(CFG_SPARE_HI, TIME_W'($urandom));
    cfg_write(CFG_ANIM_LENGTH, cur_len);
    set_count(cnt);
    load_table();
    if (phase_no == 0) hold_req <= ~hold_req;
    n_items = $urandom_range(45, 25);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 15)
        send_load($urandom_range(MAX_KEYFRAMES_DEF - 1, 0), TIME_W'($urandom));
      else
        send_query(pick_query_time());
    end
  endtask

  initial begin
    int phase_no;
    for (int i = 0; i < MAX_KEYFRAMES_DEF; i++) tb_keys[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset
    send_query(32'd5);

    wait_idle();
    cfg_write(CFG_ANIM_LENGTH, 31'd1000);
    set_count(4);
    send_load(0, 31'd0);
    send_load(1, 31'd250);
    send_load(2, 31'd500);
    send_load(3, 31'd1000);
    send_query(32'hFFFF_FFFF);
    send_query(32'h8000_0000);
    send_query(32'd0);
    send_query(32'd250);
    send_query(32'd249);
    send_query(32'd1000);       // wrap onto a zero-width tail
    send_query(32'd1001);
    send_query(32'h7FFF_FFFF);
    send_query(32'd999);
    send_query(32'd375);

    // single key: always wraps back to key 0
    wait_idle();
    set_count(1);
    send_query(32'd500);

    // unused register indexes must not disturb anything
    wait_idle();
    cfg_write(CFG_SPARE_LO, TIME_W'($urandom));
    cfg_write(CFG_SPARE_HI, TIME_W'($urandom));
    set_count(2);
    send_load(0, 31'd600);
    send_load(1, 31'd600);
    send_query(32'd300);
    send_query(32'd700);
    send_load(1, 31'd200);      // table now out of order
    send_query(32'd100);
    send_query(32'd400);

    wait_idle();
    cfg_write(CFG_ANIM_LENGTH, LEN_MAX);
    send_query(32'h7FFF_FFFF);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase_no);
      phase_no++;
    end

    wait_idle();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
